// ----- sv/acit_pkg.sv -----
package acit_pkg;

  localparam int DIVIDEND_W = 64;
  localparam int DIVISOR_W  = 32;
  localparam int STEP_W     = $clog2(DIVIDEND_W);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

  localparam logic [1:0] CMD_CHECK = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_RESET = 2'd2;

  localparam logic [15:0] INTERVAL_RST = 16'd100;
  localparam logic [30:0] EST_MAX      = 31'h7FFF_FFFF;
  localparam logic [31:0] LEFT_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] LEFT_MIN     = 32'h8000_0000;
  localparam logic [15:0] MISS_MAX     = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_RES
  } state_t;

  typedef enum logic [1:0] {
    OP_LATE_EST,
    OP_LATE_LEFT,
    OP_EARLY
  } op_t;

endpackage

// ----- sv/acit_div.sv -----
module acit_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [acit_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [acit_pkg::DIVISOR_W-1:0]  divisor,
  output logic                           done,
  output logic [acit_pkg::DIVIDEND_W-1:0] quotient
);
  import acit_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [STEP_W-1:0]     cnt_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  dvs_r;

  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W+1:0]  trial;
  logic                  ge;

  assign shifted = {rem_r, quo_r[DIVIDEND_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_r};
  assign ge      = ~trial[DIVISOR_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVIDEND_W-2:0], ge};
      rem_r <= ge ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- sv/adaptive_call_count_interval_timer_core.sv -----
// Start commands, checks that do not read the clock, and checks that read the clock
// but match exactly go straight from idle to the result state.
// Early and late checks rescale the estimate: each rescale uses the
// shared 64-step serial divider once (early) or twice (late). One request at a time.
// Reset (rst_n low, synchronous): interval 100, estimate 1, all counters zero.
module adaptive_call_count_interval_timer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_now_msec,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_expired,
  output logic [15:0] out_miss_count
);
  import acit_pkg::*;

  state_t      state_r, state_nxt;
  op_t         op_r, op_nxt;
  logic [15:0] interval_r;
  logic [31:0] calls_left_r, calls_left_nxt;
  logic [30:0] est_r, est_nxt;
  logic [31:0] period_r, period_nxt;
  logic [15:0] misses_r, misses_nxt;
  logic [31:0] mul_a_r, mul_a_nxt;
  logic [31:0] mul_b_r, mul_b_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [31:0] err_r, err_nxt;
  logic        res_exp_r, res_exp_nxt;
  logic        out_valid_r;
  logic        out_expired_r;
  logic [15:0] out_miss_r;

  logic [15:0] ivl;
  logic        accept;
  logic        load_out;
  logic        div_start;
  logic        div_done;
  logic [63:0] product;
  logic [63:0] quo;
  logic [31:0] cl_dec;
  logic [31:0] elapsed;
  logic [31:0] diff;
  logic [65:0] left_s;
  logic [63:0] cnt;
  logic [64:0] est_sum;

  assign ivl      = (interval_r == 16'd0) ? 16'd1 : interval_r;
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign load_out = (state_r == ST_RES) && (!out_valid_r || !out_stall);
  assign product  = {32'd0, mul_a_r} * {32'd0, mul_b_r};
  assign cl_dec   = (calls_left_r == LEFT_MIN) ? calls_left_r : calls_left_r - 32'd1;
  assign elapsed  = in_now_msec - period_r;
  assign diff     = elapsed - {16'd0, ivl};
  assign left_s   = {35'd0, est_r} - {2'b00, quo};
  assign cnt      = (quo != 64'd0) ? quo :
                    (est_r == 31'd0) ? 64'd1 : {32'd0, est_r, 1'b0};
  assign est_sum  = {1'b0, cnt} + {34'd0, est_r};

  acit_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (product),
    .divisor  (dvs_r),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      op_r         <= OP_EARLY;
      interval_r   <= INTERVAL_RST;
      calls_left_r <= '0;
      est_r        <= 31'd1;
      period_r     <= '0;
      misses_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      op_r         <= op_nxt;
      calls_left_r <= calls_left_nxt;
      est_r        <= est_nxt;
      period_r     <= period_nxt;
      misses_r     <= misses_nxt;
      if (cfg_we) begin
        interval_r <= cfg_wdata;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mul_a_r   <= mul_a_nxt;
    mul_b_r   <= mul_b_nxt;
    dvs_r     <= dvs_nxt;
    err_r     <= err_nxt;
    res_exp_r <= res_exp_nxt;
    if (load_out) begin
      out_expired_r <= res_exp_r;
      out_miss_r    <= misses_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    calls_left_nxt = calls_left_r;
    est_nxt        = est_r;
    period_nxt     = period_r;
    misses_nxt     = misses_r;
    mul_a_nxt      = mul_a_r;
    mul_b_nxt      = mul_b_r;
    dvs_nxt        = dvs_r;
    err_nxt        = err_r;
    res_exp_nxt    = res_exp_r;
    div_start      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_exp_nxt = 1'b0;
          state_nxt   = ST_RES;
          unique case (in_cmd)
            CMD_START: begin
              calls_left_nxt = {1'b0, est_r};
              period_nxt     = in_now_msec;
            end
            CMD_RESET: begin
              calls_left_nxt = '0;
              est_nxt        = 31'd1;
              period_nxt     = in_now_msec;
            end
            CMD_CHECK: begin
              calls_left_nxt = cl_dec;
              if (cl_dec[31]) begin
                if (diff == 32'd0) begin
                  calls_left_nxt = {1'b0, est_r};
                  period_nxt     = in_now_msec;
                  misses_nxt     = '0;
                  res_exp_nxt    = 1'b1;
                end else begin
                  if (misses_r != MISS_MAX) begin
                    misses_nxt = misses_r + 16'd1;
                  end
                  mul_a_nxt = {1'b0, est_r};
                  err_nxt   = diff;
                  state_nxt = ST_MUL;
                  if (!diff[31]) begin
                    op_nxt    = OP_LATE_EST;
                    mul_b_nxt = {16'd0, ivl};
                    dvs_nxt   = elapsed;
                  end else begin
                    op_nxt    = OP_EARLY;
                    mul_b_nxt = 32'd0 - diff;
                    dvs_nxt   = {16'd0, ivl};
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MUL: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          unique case (op_r)
            OP_LATE_EST: begin
              est_nxt   = (quo[63:31] != 33'd0) ? EST_MAX : quo[30:0];
              mul_a_nxt = {1'b0, est_nxt};
              mul_b_nxt = err_r;
              dvs_nxt   = {16'd0, ivl};
              op_nxt    = OP_LATE_LEFT;
              state_nxt = ST_MUL;
            end
            OP_LATE_LEFT: begin
              if ((left_s[65:31] == '0) || (left_s[65:31] == '1)) begin
                calls_left_nxt = left_s[31:0];
              end else begin
                calls_left_nxt = LEFT_MIN;
              end
              period_nxt  = period_r + {16'd0, ivl};
              res_exp_nxt = 1'b1;
              state_nxt   = ST_RES;
            end
            OP_EARLY: begin
              est_nxt        = (est_sum[64:31] != 34'd0) ? EST_MAX : est_sum[30:0];
              calls_left_nxt = (cnt[63:31] != 33'd0) ? LEFT_MAX : cnt[31:0];
              res_exp_nxt    = 1'b0;
              state_nxt      = ST_RES;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_RES: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_expired    = out_expired_r;
  assign out_miss_count = out_miss_r;

endmodule

// ----- sv/acit_checker.sv -----
module acit_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_we,
  input logic [15:0] cfg_wdata,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_cmd,
  input logic [31:0] in_now_msec,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_expired,
  input logic [15:0] out_miss_count
);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("outputs not cleared by reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while another in flight");

  a_result_from_request: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without request in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_expired) && $stable(out_miss_count))
    else $error("stalled result changed");

endmodule

bind adaptive_call_count_interval_timer_core acit_checker u_acit_checker (.*);
